// File: rtl/esc_pkg.sv
package esc_pkg;

    // low code of the character range, subtracted on encrypt and added back on decrypt
    localparam logic [15:0] CODE_OFFSET = 16'd31;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPHEMERAL_EXP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_KEY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_KEY    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SENDER_COMMIT  = 3'd6;

    // what the multipliers work on in one pass
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_EXP,
        OP_FINAL
    } t_mm_op;

    typedef struct packed {
        logic   load;
        logic   mm_start;
        logic   mm_step;
        logic   latch;
        t_mm_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic err;
    } t_dp_stat;

endpackage

// File: rtl/esc_modmul.sv
module esc_modmul #(
    parameter int W  = 16,
    parameter int LW = 16
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic          i_step,
    input  logic [LW-1:0] i_a,
    input  logic [W-1:0]  i_b,
    input  logic [W-1:0]  i_m,
    output logic [W-1:0]  o_prod
);

    logic [LW-1:0] r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;

    logic [W+1:0]  t0;
    logic [W+1:0]  t1;
    logic [W+1:0]  t2;
    logic [W+1:0]  m_ext;

    // msb-first interleaved multiply: acc = 2*acc + bit*b, stays below 3m before reduction
    always_comb begin
        m_ext = {2'b00, i_m};
        t0    = {1'b0, r_acc, 1'b0} + (r_a[LW-1] ? {2'b00, r_b} : '0);
        t1    = (t0 >= m_ext) ? (t0 - m_ext) : t0;
        t2    = (t1 >= m_ext) ? (t1 - m_ext) : t1;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_step) begin
            r_a   <= {r_a[LW-2:0], 1'b0};
            r_acc <= t2[W-1:0];
        end
    end

    assign o_prod = r_acc;

endmodule

// File: rtl/esc_datapath.sv
module esc_datapath #(
    parameter int W  = 16,
    parameter int LW = 16
) (
    input  logic              i_clk,
    input  esc_pkg::t_dp_cmd  i_cmd,
    output esc_pkg::t_dp_stat o_stat,
    input  logic [W-1:0]      i_modulus,
    input  logic [W-1:0]      i_generator,
    input  logic              i_decrypt_mode,
    input  logic [W-1:0]      i_ephemeral_exponent,
    input  logic [W-1:0]      i_peer_public_key,
    input  logic [W-1:0]      i_private_key,
    input  logic [W-1:0]      i_sender_commitment,
    input  logic [15:0]       i_symbol,
    output logic [15:0]       o_result_value,
    output logic [15:0]       o_companion_key,
    output logic              o_error_flag
);

    import esc_pkg::*;

    logic [LW-1:0] r_sym_op;
    logic [W-1:0]  r_acc1;
    logic [W-1:0]  r_acc2;
    logic [W-1:0]  r_b1;
    logic [W-1:0]  r_b2;
    logic [W-1:0]  r_e1;
    logic [W-1:0]  r_e2;
    logic          r_err;
    logic          r_dec;
    logic [15:0]   r_res;

    logic          n_err;
    logic [W-1:0]  one_w;
    logic [LW-1:0] a0;
    logic [LW-1:0] a1;
    logic [W-1:0]  b0;
    logic [W-1:0]  b1;
    logic [W-1:0]  p0;
    logic [W-1:0]  p1;
    logic [W-1:0]  p2;
    logic [W-1:0]  p3;
    logic [LW-1:0] p0_wide;
    logic [LW-1:0] comp_wide;
    logic [7:0]    dec_code;

    assign one_w = W'(1);

    always_comb begin
        n_err = (i_modulus < W'(2));
        if (i_decrypt_mode) begin
            n_err = n_err || (({1'b0, i_private_key} + (W+1)'(2)) > {1'b0, i_modulus});
        end else begin
            n_err = n_err || (i_symbol < CODE_OFFSET);
        end
    end

    // operand select for the two lanes that change role between passes
    always_comb begin
        case (i_cmd.op)
            OP_REDUCE: begin
                a0 = LW'(r_b1);
                b0 = one_w;
                a1 = LW'(r_b2);
                b1 = one_w;
            end
            OP_EXP: begin
                a0 = LW'(r_acc1);
                b0 = r_b1;
                a1 = LW'(r_b1);
                b1 = r_b1;
            end
            OP_FINAL: begin
                a0 = r_sym_op;
                b0 = r_acc1;
                a1 = LW'(r_b1);
                b1 = r_b1;
            end
            default: begin
                a0 = LW'(r_acc1);
                b0 = r_b1;
                a1 = LW'(r_b1);
                b1 = r_b1;
            end
        endcase
    end

    esc_modmul #(.W(W), .LW(LW)) u_mm0 (
        .i_clk   (i_clk),
        .i_start (i_cmd.mm_start),
        .i_step  (i_cmd.mm_step),
        .i_a     (a0),
        .i_b     (b0),
        .i_m     (i_modulus),
        .o_prod  (p0)
    );

    esc_modmul #(.W(W), .LW(LW)) u_mm1 (
        .i_clk   (i_clk),
        .i_start (i_cmd.mm_start),
        .i_step  (i_cmd.mm_step),
        .i_a     (a1),
        .i_b     (b1),
        .i_m     (i_modulus),
        .o_prod  (p1)
    );

    esc_modmul #(.W(W), .LW(LW)) u_mm2 (
        .i_clk   (i_clk),
        .i_start (i_cmd.mm_start),
        .i_step  (i_cmd.mm_step),
        .i_a     (LW'(r_acc2)),
        .i_b     (r_b2),
        .i_m     (i_modulus),
        .o_prod  (p2)
    );

    esc_modmul #(.W(W), .LW(LW)) u_mm3 (
        .i_clk   (i_clk),
        .i_start (i_cmd.mm_start),
        .i_step  (i_cmd.mm_step),
        .i_a     (LW'(r_b2)),
        .i_b     (r_b2),
        .i_m     (i_modulus),
        .o_prod  (p3)
    );

    assign p0_wide  = LW'(p0);
    assign dec_code = p0[7:0] + CODE_OFFSET[7:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= n_err;
            r_dec <= i_decrypt_mode;
            r_b2  <= i_generator;
            if (i_decrypt_mode) begin
                r_e1     <= i_modulus - one_w - i_private_key;
                r_e2     <= i_private_key;
                r_b1     <= i_sender_commitment;
                r_sym_op <= LW'(i_symbol);
            end else begin
                r_e1     <= i_ephemeral_exponent;
                r_e2     <= i_ephemeral_exponent;
                r_b1     <= i_peer_public_key;
                r_sym_op <= LW'(i_symbol - CODE_OFFSET);
            end
        end else if (i_cmd.latch) begin
            case (i_cmd.op)
                OP_REDUCE: begin
                    r_b1   <= p0;
                    r_b2   <= p1;
                    r_acc1 <= one_w;
                    r_acc2 <= one_w;
                end
                OP_EXP: begin
                    // one exponent bit, lsb first
                    if (r_e1[0]) begin
                        r_acc1 <= p0;
                    end
                    if (r_e2[0]) begin
                        r_acc2 <= p2;
                    end
                    r_b1 <= p1;
                    r_b2 <= p3;
                    r_e1 <= r_e1 >> 1;
                    r_e2 <= r_e2 >> 1;
                end
                OP_FINAL: begin
                    if (r_dec) begin
                        r_res <= {8'h00, dec_code};
                    end else begin
                        r_res <= p0_wide[15:0];
                    end
                end
                default: begin
                    r_res <= r_res;
                end
            endcase
        end
    end

    assign comp_wide       = LW'(r_acc2);
    assign o_stat.err      = r_err;
    assign o_result_value  = r_err ? 16'h0000 : r_res;
    assign o_companion_key = r_err ? 16'h0000 : comp_wide[15:0];
    assign o_error_flag    = r_err;

endmodule

// File: rtl/esc_ctrl.sv
module esc_ctrl #(
    parameter int W  = 16,
    parameter int LW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  esc_pkg::t_dp_stat i_stat,
    output esc_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    import esc_pkg::*;

    localparam int CW = $clog2(LW);
    localparam int BW = $clog2(W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_RUN,
        S_LATCH
    } t_state;

    t_state        r_state;
    t_mm_op        r_phase;
    logic [CW-1:0] r_cnt;
    logic [BW-1:0] r_bit;
    logic          r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= OP_REDUCE;
            r_cnt   <= '0;
            r_bit   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_START;
                        r_phase <= OP_REDUCE;
                    end
                end
                S_START: begin
                    if (i_stat.err) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                    end
                end
                S_RUN: begin
                    if (r_cnt == CW'(LW - 1)) begin
                        r_state <= S_LATCH;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_LATCH: begin
                    case (r_phase)
                        OP_REDUCE: begin
                            r_phase <= OP_EXP;
                            r_bit   <= '0;
                            r_state <= S_START;
                        end
                        OP_EXP: begin
                            if (r_bit == BW'(W - 1)) begin
                                r_phase <= OP_FINAL;
                            end else begin
                                r_bit <= r_bit + BW'(1);
                            end
                            r_state <= S_START;
                        end
                        OP_FINAL: begin
                            r_state <= S_IDLE;
                            r_valid <= 1'b1;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.mm_start = (r_state == S_START) && !i_stat.err;
        o_cmd.mm_step  = (r_state == S_RUN);
        o_cmd.latch    = (r_state == S_LATCH);
        o_cmd.op       = r_phase;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// File: rtl/elgamal_symbol_cipher.sv
// ElGamal cipher over a small prime modulus, one symbol per command. Pulse i_start
// with o_busy low to hand in a symbol; the result beat shows on the o_ ports for
// exactly one cycle with o_valid high and cannot be held off, so the receiver must
// take it then. Encrypt gives the ciphertext and r = generator^k mod P; decrypt gives
// the character code in the low 8 bits and the own public key. A symbol runs a reduce
// pass, an exponent pass for each of the MOD_WIDTH exponent bits and a final pass,
// each starting, stepping and latching the multipliers. Every modular product runs
// through a bit-serial interleaved multiplier at one operand bit per cycle, four of
// them in parallel. Error items (encrypt code below 31, decrypt private key above P-2,
// modulus below 2) finish in the start state without a multiplier pass. A new symbol
// may be started in the cycle that o_valid is shown. The user must write configuration
// through i_cfg_we/i_cfg_index/i_cfg_wdata while o_busy is low; it is not enforced.
module elgamal_symbol_cipher #(
    parameter int MOD_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [15:0]                  i_symbol,
    output logic                         o_valid,
    output logic [15:0]                  o_result_value,
    output logic [15:0]                  o_companion_key,
    output logic                         o_error_flag,
    input  logic                         i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MOD_WIDTH-1:0]         i_cfg_wdata
);

    import esc_pkg::*;

    localparam int W  = MOD_WIDTH;
    localparam int LW = (MOD_WIDTH > 16) ? MOD_WIDTH : 16;

    logic [W-1:0] r_modulus;
    logic [W-1:0] r_generator;
    logic         r_decrypt_mode;
    logic [W-1:0] r_ephemeral_exponent;
    logic [W-1:0] r_peer_public_key;
    logic [W-1:0] r_private_key;
    logic [W-1:0] r_sender_commitment;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus            <= W'(211);
            r_generator          <= W'(2);
            r_decrypt_mode       <= 1'b0;
            r_ephemeral_exponent <= W'(1);
            r_peer_public_key    <= W'(1);
            r_private_key        <= W'(1);
            r_sender_commitment  <= W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODULUS:       r_modulus            <= i_cfg_wdata;
                REG_GENERATOR:     r_generator          <= i_cfg_wdata;
                REG_DECRYPT_MODE:  r_decrypt_mode       <= i_cfg_wdata[0];
                REG_EPHEMERAL_EXP: r_ephemeral_exponent <= i_cfg_wdata;
                REG_PEER_KEY:      r_peer_public_key    <= i_cfg_wdata;
                REG_PRIVATE_KEY:   r_private_key        <= i_cfg_wdata;
                REG_SENDER_COMMIT: r_sender_commitment  <= i_cfg_wdata;
                default: begin
                    r_modulus <= r_modulus;
                end
            endcase
        end
    end

    esc_ctrl #(.W(W), .LW(LW)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    esc_datapath #(.W(W), .LW(LW)) u_dp (
        .i_clk                (i_clk),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_modulus            (r_modulus),
        .i_generator          (r_generator),
        .i_decrypt_mode       (r_decrypt_mode),
        .i_ephemeral_exponent (r_ephemeral_exponent),
        .i_peer_public_key    (r_peer_public_key),
        .i_private_key        (r_private_key),
        .i_sender_commitment  (r_sender_commitment),
        .i_symbol             (i_symbol),
        .o_result_value       (o_result_value),
        .o_companion_key      (o_companion_key),
        .o_error_flag         (o_error_flag)
    );

`ifndef SYNTHESIS
    a_valid_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result beat while busy");

    a_accept_goes_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted symbol did not start work");

    a_single_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    a_error_zeroes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_flag) |-> (o_result_value == 16'h0000 &&
                                       o_companion_key == 16'h0000))
        else $error("error beat carries data");
`endif

endmodule
